@@ src/osp_pkg.sv @@
// Shared types, constants and character classes for the option symbol parser.
package osp_pkg;

    // Symbol layout, by character position
    localparam logic [7:0] SymLen     = 8'd21;
    localparam logic [7:0] RootW      = 8'd6;
    localparam logic [7:0] MonthHiPos = 8'd8;
    localparam logic [7:0] MonthLoPos = 8'd9;
    localparam logic [7:0] TypePos    = 8'd12;
    localparam logic [7:0] PosMax     = 8'd255;

    // Character codes
    localparam logic [7:0] CharZero = 8'd48;
    localparam logic [7:0] CharCall = 8'd67;
    localparam logic [7:0] CharPut  = 8'd80;
    localparam logic [11:0] YearBase = 12'd2000;

    // Per-line parse state
    typedef struct packed {
        logic [7:0]  position;
        logic        still_ok;
        logic [47:0] root_store;
        logic [2:0]  root_count;
        logic        in_padding;
        logic [6:0]  year_digits;
        logic [3:0]  month_value;
        logic [6:0]  day_value;
        logic        put_flag;
        logic [26:0] strike_acc;
    } t_parse_state;

    localparam t_parse_state StateReset = '{
        position:    8'd0,
        still_ok:    1'b1,
        root_store:  48'd0,
        root_count:  3'd0,
        in_padding:  1'b0,
        year_digits: 7'd0,
        month_value: 4'd0,
        day_value:   7'd0,
        put_flag:    1'b0,
        strike_acc:  27'd0
    };

    // One result beat
    typedef struct packed {
        logic        valid_res;
        logic [47:0] root_chars;
        logic [2:0]  root_len;
        logic [11:0] year;
        logic [3:0]  month;
        logic [6:0]  day;
        logic        is_put;
        logic [26:0] strike_milli;
        logic [7:0]  line_length;
    } t_result;

    function automatic logic is_cap(input logic [7:0] c);
        return (c >= 8'd65) && (c <= 8'd90);
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

endpackage

@@ src/osp_char_step.sv @@
// Next parse state and end-of-line result for one character.
module osp_char_step import osp_pkg::*; (
    input  t_parse_state i_cur,
    input  logic [7:0]   i_char_code,
    input  logic         i_end_of_line,
    output t_parse_state o_next,
    output t_result      o_res
);

    logic [7:0]   w_d;
    logic [3:0]   w_d4;
    logic [10:0]  w_year_sum;
    logic [7:0]   w_month_sum;
    logic [10:0]  w_day_sum;
    logic [30:0]  w_strike_sum;
    logic [7:0]   w_pos_next;
    t_parse_state w_upd;
    logic         w_ok;

    assign w_d  = i_char_code - CharZero;
    assign w_d4 = w_d[3:0];

    // Multiply-by-ten accumulates as shift-and-add
    assign w_year_sum   = ({4'd0, i_cur.year_digits} << 3) + ({4'd0, i_cur.year_digits} << 1)
                        + {7'd0, w_d4};
    assign w_month_sum  = ({4'd0, i_cur.month_value} << 3) + ({4'd0, i_cur.month_value} << 1)
                        + {4'd0, w_d4};
    assign w_day_sum    = ({4'd0, i_cur.day_value} << 3) + ({4'd0, i_cur.day_value} << 1)
                        + {7'd0, w_d4};
    assign w_strike_sum = ({4'd0, i_cur.strike_acc} << 3) + ({4'd0, i_cur.strike_acc} << 1)
                        + {27'd0, w_d4};

    assign w_pos_next = (i_cur.position < PosMax) ? i_cur.position + 8'd1 : i_cur.position;

    // Check the character against its position and fold it into the fields
    always_comb begin
        w_upd = i_cur;
        w_upd.position = w_pos_next;
        if (i_cur.position >= SymLen) begin
            w_upd.still_ok = 1'b0;
        end else if (i_cur.position < RootW) begin
            w_upd.root_store = {i_cur.root_store[39:0], i_char_code};
            if (i_cur.position == 8'd0) begin
                if (is_cap(i_char_code)) w_upd.root_count = 3'd1;
                else                     w_upd.still_ok = 1'b0;
            end else if (i_cur.in_padding) begin
                if (!is_ws(i_char_code)) w_upd.still_ok = 1'b0;
            end else if (is_cap(i_char_code)) begin
                w_upd.root_count = i_cur.root_count + 3'd1;
            end else if (is_ws(i_char_code)) begin
                w_upd.in_padding = 1'b1;
            end else begin
                w_upd.still_ok = 1'b0;
            end
        end else if (i_cur.position == TypePos) begin
            if (i_char_code == CharCall)     w_upd.put_flag = 1'b0;
            else if (i_char_code == CharPut) w_upd.put_flag = 1'b1;
            else                             w_upd.still_ok = 1'b0;
        end else if (!is_dig(i_char_code)) begin
            w_upd.still_ok = 1'b0;
        end else if (i_cur.position < MonthHiPos) begin
            w_upd.year_digits = w_year_sum[6:0];
        end else if (i_cur.position == MonthHiPos) begin
            if (w_d4 > 4'd1) w_upd.still_ok = 1'b0;
            w_upd.month_value = {3'd0, w_d4[0]};
        end else if (i_cur.position == MonthLoPos) begin
            if (i_cur.month_value == 4'd0) begin
                if (w_d4 == 4'd0) w_upd.still_ok = 1'b0;
            end else if (w_d4 > 4'd2) begin
                w_upd.still_ok = 1'b0;
            end
            w_upd.month_value = w_month_sum[3:0];
        end else if (i_cur.position < TypePos) begin
            w_upd.day_value = w_day_sum[6:0];
        end else begin
            w_upd.strike_acc = w_strike_sum[26:0];
        end
    end

    assign w_ok = w_upd.still_ok && (w_upd.position == SymLen);

    // Build the result; zero every field but the count on a bad line
    always_comb begin
        o_res = '0;
        if (w_ok) begin
            o_res.valid_res    = 1'b1;
            o_res.root_chars   = w_upd.root_store;
            o_res.root_len     = w_upd.root_count;
            o_res.year         = YearBase + {5'd0, w_upd.year_digits};
            o_res.month        = w_upd.month_value;
            o_res.day          = w_upd.day_value;
            o_res.is_put       = w_upd.put_flag;
            o_res.strike_milli = w_upd.strike_acc;
        end
        o_res.line_length = w_upd.position;
    end

    // Start a fresh line after the marked character
    assign o_next = i_end_of_line ? StateReset : w_upd;

endmodule

@@ src/osp_out_reg.sv @@
// Result register with valid flag between the parser and the output channel.
module osp_out_reg import osp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Slot is free when empty or being drained this cycle
    assign o_free = !r_valid || i_ready;

    // Hold valid until taken; load a new beat into a free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ src/osi_option_symbol_parser.sv @@
// Option symbol parser: one character per beat, one result beat per line.
// The result of a line is registered and on the output the cycle after its last character is accepted.
// Throughput: one character per cycle, set by the single per-character update.
// A full result register stalls input only while its beat is not taken.
// Reset (synchronous, active low) clears the line state and empties the result register.
module osi_option_symbol_parser import osp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_line,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_valid_res,
    output logic [47:0] o_root_chars,
    output logic [2:0]  o_root_len,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [6:0]  o_day,
    output logic        o_is_put,
    output logic [26:0] o_strike_milli,
    output logic [7:0]  o_line_length
);

    t_parse_state r_state;
    t_parse_state n_state;
    t_result      w_res;
    t_result      w_out;
    logic         w_free;
    logic         w_accept;

    assign o_ready  = w_free;
    assign w_accept = i_valid && w_free;

    osp_char_step u_step (
        .i_cur         (r_state),
        .i_char_code   (i_char_code),
        .i_end_of_line (i_end_of_line),
        .o_next        (n_state),
        .o_res         (w_res)
    );

    // Advance the line state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StateReset;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    osp_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept && i_end_of_line),
        .i_res   (w_res),
        .i_ready (i_ready),
        .o_free  (w_free),
        .o_valid (o_valid),
        .o_res   (w_out)
    );

    assign o_valid_res    = w_out.valid_res;
    assign o_root_chars   = w_out.root_chars;
    assign o_root_len     = w_out.root_len;
    assign o_year         = w_out.year;
    assign o_month        = w_out.month;
    assign o_day          = w_out.day;
    assign o_is_put       = w_out.is_put;
    assign o_strike_milli = w_out.strike_milli;
    assign o_line_length  = w_out.line_length;

`ifndef SYNTH
    // A good line is always exactly one symbol long
    a_valid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_res |-> o_line_length == SymLen)
        else $error("valid result with wrong line length");

    // A bad line carries only its count
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_valid_res |-> o_root_chars == 48'd0 && o_year == 12'd0
            && o_strike_milli == 27'd0 && o_root_len == 3'd0)
        else $error("invalid result with nonzero fields");

    // End of line yields a result beat and restarts the line
    a_eol_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_end_of_line |=> o_valid && r_state.position == 8'd0)
        else $error("end of line did not produce a result or restart");
`endif

endmodule
